FILE: hw/rtl/mps_pkg.sv
// Package for the Moran process step core: widths, reset values, register
// indexes and the sequencer state type. Depends on nothing.
`default_nettype none

package mps_pkg;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam int POP_W      = 16;
   localparam int FIT_W      = 16;
   localparam int RATE_W     = 16;
   localparam int SCALE_W    = 32;
   localparam int GEN_W      = 20;
   localparam int RAND_W     = 16;
   localparam int OUT_CNT_W  = 16;
   localparam int DET_W      = 32;
   localparam int STEPS_W    = 40;
   localparam int LIMIT_W    = 36;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int MUL_B_W    = 32;

   localparam logic [POP_W-1:0] POP_RESET = 16'd1000;
   localparam logic [FIT_W-1:0] FIT_RESET = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POP   = 3'd0,
      CSR_FIT   = 3'd1,
      CSR_RATE  = 3'd2,
      CSR_SCALE = 3'd3,
      CSR_GEN   = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_FIT,
      ST_WSUM,
      ST_BLO,
      ST_BHI,
      ST_BCMP,
      ST_DMUL,
      ST_DCMP,
      ST_DET1,
      ST_DET2,
      ST_DET3,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mps_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on mps_pkg for the width of the second operand.
`default_nettype none

module mps_mul #(
   parameter int A_W = 32
) (
   input  logic                             clock,
   input  logic [A_W-1:0]                   a,
   input  logic [mps_pkg::MUL_B_W-1:0]      b,
   output logic [A_W+mps_pkg::MUL_B_W-1:0]  prod
);
   import mps_pkg::*;

   logic [A_W+MUL_B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (A_W+MUL_B_W)'(a) * (A_W+MUL_B_W)'(b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/moran_process_step_core.sv
// Moran process step core: one birth-death step of a two-type population per beat.
// Requests are taken only in the idle state, so a new beat waits until the response beat of
// the last one is taken; the step computes eight products in turn on the one shared multiplier.
// Synchronous active-high reset restores the register defaults, sets the wild count to the
// default population and clears the mutant count, detection total, step count and active flag.
`default_nettype none

module moran_process_step_core #(
   parameter int COUNT_WIDTH = mps_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_wr_en,
   input  logic [mps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   input  logic [mps_pkg::RAND_W-1:0]         req_rand_birth,
   input  logic [mps_pkg::RAND_W-1:0]         req_rand_mutate,
   input  logic [mps_pkg::RAND_W-1:0]         req_rand_death,
   input  logic [mps_pkg::RAND_W-1:0]         req_rand_detect,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mps_pkg::OUT_CNT_W-1:0]      rsp_wild_count,
   output logic [mps_pkg::OUT_CNT_W-1:0]      rsp_mutant_count,
   output logic                               rsp_detected_now,
   output logic [mps_pkg::DET_W-1:0]          rsp_detection_total,
   output logic                               rsp_finished
);
   import mps_pkg::*;

   // Count width, and the width of a count sum that may briefly pass the maximum
   // between birth and death.
   localparam int CW       = COUNT_WIDTH;
   localparam int SUM_W    = CW + 1;
   localparam int MUL_A_W  = (SUM_W > 32) ? SUM_W : 32;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   // Birth weight 256*wt + fit*mt and its product with the birth fraction.
   localparam int WGT_W    = CW + FIT_W + 1;
   localparam int BPROD_W  = WGT_W + RAND_W;
   localparam int DPROD_W  = SUM_W + RAND_W;
   localparam int RHS_W    = 2 * POP_W + RAND_W;
   localparam logic [CW-1:0] CNT_MAX = '1;
   localparam logic [STEPS_W-1:0] STEPS_MAX = '1;
   localparam logic [DET_W-1:0]   DET_MAX   = '1;

   // Population size limited to what a count register can hold.
   function automatic logic [CW-1:0] sat_pop(input logic [POP_W-1:0] n);
      logic [CW-1:0] r;
      if (64'(n) > 64'(CNT_MAX)) begin
         r = CNT_MAX;
      end else begin
         r = CW'(n);
      end
      return r;
   endfunction

   // Sequencer state.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [POP_W-1:0]   pop_ff;
   logic [FIT_W-1:0]   fit_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [GEN_W-1:0]   gen_ff;

   // Process state carried from one step to the next.
   logic [CW-1:0]      wt_ff, mt_ff;
   logic [DET_W-1:0]   det_total_ff;
   logic [STEPS_W-1:0] steps_ff;

   // Per-step working registers.
   logic [RAND_W-1:0]  rb_ff, rm_ff, rd_ff, rd2_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               active_ff;
   logic [WGT_W-1:0]   weight_ff;
   logic [RAND_W+31:0] lo_ff;
   logic [SUM_W-1:0]   wb_ff, mb_ff;
   logic [RHS_W-1:0]   rhs_ff;

   // Response registers.
   logic [OUT_CNT_W-1:0] rsp_wild_ff, rsp_mutant_ff;
   logic                 rsp_det_ff, rsp_fin_ff;
   logic [DET_W-1:0]     rsp_total_ff;

   // Shared multiplier.
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;

   // Datapath terms.
   logic [63:0]        weight_pad;
   logic [SUM_W-1:0]   cnt_sum;
   logic [BPROD_W-1:0] birth_lhs, birth_rhs;
   logic               mutant_parent;
   logic [SUM_W-1:0]   wb_in, mb_in;
   logic [DPROD_W-1:0] death_lhs, death_rhs;
   logic               wild_dies;
   logic [SUM_W-1:0]   wd_in, md_in;
   logic               det_hit;
   logic [STEPS_W-1:0] steps_in;
   logic               req_take;

   mps_mul #(
      .A_W (MUL_A_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign req_take   = req_valid && !req_stall;
   assign weight_pad = 64'(weight_ff);
   assign cnt_sum    = wb_ff + mb_ff;

   // Birth: the parent is a mutant when rb*weight exceeds 2^24*wt. The product
   // arrives as a high partial product (in prod) and a low one (in lo_ff).
   assign birth_lhs     = (BPROD_W'(prod) << 32) + BPROD_W'(lo_ff);
   assign birth_rhs     = BPROD_W'(wt_ff) << 24;
   assign mutant_parent = birth_lhs > birth_rhs;

   always_comb begin
      wb_in = SUM_W'(wt_ff);
      mb_in = SUM_W'(mt_ff);
      if ((mt_ff != '0) && ((wt_ff == '0) || mutant_parent)) begin
         mb_in = SUM_W'(mt_ff) + SUM_W'(1);
      end else if (rm_ff <= rate_ff) begin
         // A wild-type daughter that mutates.
         mb_in = SUM_W'(mt_ff) + SUM_W'(1);
      end else begin
         wb_in = SUM_W'(wt_ff) + SUM_W'(1);
      end
   end

   // Death: a wild-type cell dies when rd*(wt+mt) <= 65536*wt, with the counts
   // after birth. An empty type is never picked.
   assign death_lhs = prod[DPROD_W-1:0];
   assign death_rhs = DPROD_W'(wb_ff) << 16;
   assign wild_dies = (wb_ff != '0) && ((mb_ff == '0) || (death_lhs <= death_rhs));

   always_comb begin
      wd_in = wb_ff;
      md_in = mb_ff;
      if (wild_dies) begin
         wd_in = wb_ff - SUM_W'(1);
      end else begin
         md_in = mb_ff - SUM_W'(1);
      end
   end

   // Detection: mt*scale against rd2*N^2, only on a step that runs.
   assign det_hit  = active_ff && (prod > MUL_P_W'(rhs_ff));
   assign steps_in = (active_ff && (steps_ff != STEPS_MAX)) ? steps_ff + STEPS_W'(1)
                                                            : steps_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_FIT;
         ST_FIT:   state_in = ST_WSUM;
         ST_WSUM:  state_in = ST_BLO;
         ST_BLO:   state_in = ST_BHI;
         ST_BHI:   state_in = ST_BCMP;
         ST_BCMP:  state_in = ST_DMUL;
         ST_DMUL:  state_in = ST_DCMP;
         ST_DCMP:  state_in = ST_DET1;
         ST_DET1:  state_in = ST_DET2;
         ST_DET2:  state_in = ST_DET3;
         ST_DET3:  state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand selection.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_LIMIT: begin
            mul_a = MUL_A_W'(pop_ff);
            mul_b = MUL_B_W'(gen_ff);
         end
         ST_FIT: begin
            mul_a = MUL_A_W'(mt_ff);
            mul_b = MUL_B_W'(fit_ff);
         end
         ST_BLO: begin
            mul_a = MUL_A_W'(weight_pad[31:0]);
            mul_b = MUL_B_W'(rb_ff);
         end
         ST_BHI: begin
            mul_a = MUL_A_W'(weight_pad[63:32]);
            mul_b = MUL_B_W'(rb_ff);
         end
         ST_DMUL: begin
            mul_a = MUL_A_W'(cnt_sum);
            mul_b = MUL_B_W'(rd_ff);
         end
         ST_DCMP: begin
            mul_a = MUL_A_W'(pop_ff);
            mul_b = MUL_B_W'(pop_ff);
         end
         ST_DET1: begin
            mul_a = MUL_A_W'(prod[2*POP_W-1:0]);
            mul_b = MUL_B_W'(rd2_ff);
         end
         ST_DET2: begin
            mul_a = MUL_A_W'(mt_ff);
            mul_b = scale_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Control state, configuration and process state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_ff       <= POP_RESET;
         fit_ff       <= FIT_RESET;
         rate_ff      <= '0;
         scale_ff     <= '0;
         gen_ff       <= '0;
         wt_ff        <= sat_pop(POP_RESET);
         mt_ff        <= '0;
         det_total_ff <= '0;
         steps_ff     <= '0;
         active_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_POP:   pop_ff   <= csr_wr_data[POP_W-1:0];
               CSR_FIT:   fit_ff   <= csr_wr_data[FIT_W-1:0];
               CSR_RATE:  rate_ff  <= csr_wr_data[RATE_W-1:0];
               CSR_SCALE: scale_ff <= csr_wr_data[SCALE_W-1:0];
               CSR_GEN:   gen_ff   <= csr_wr_data[GEN_W-1:0];
               default:   ;
            endcase
         end

         // A restart reinitializes the population before the step runs.
         if (req_take && req_restart) begin
            wt_ff        <= sat_pop(pop_ff);
            mt_ff        <= '0;
            det_total_ff <= '0;
            steps_ff     <= '0;
         end

         // The step runs only while the step budget generations*N is not used up.
         if (state_ff == ST_FIT) begin
            active_ff <= steps_ff < STEPS_W'(prod[LIMIT_W-1:0]);
         end

         if ((state_ff == ST_DCMP) && active_ff) begin
            wt_ff <= wd_in[CW] ? CNT_MAX : wd_in[CW-1:0];
            mt_ff <= md_in[CW] ? CNT_MAX : md_in[CW-1:0];
         end

         if (state_ff == ST_DET3) begin
            steps_ff <= steps_in;
            if (det_hit && (det_total_ff != DET_MAX)) begin
               det_total_ff <= det_total_ff + DET_W'(1);
            end
         end
      end
   end

   // Payload, working and response registers; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rb_ff  <= req_rand_birth;
         rm_ff  <= req_rand_mutate;
         rd_ff  <= req_rand_death;
         rd2_ff <= req_rand_detect;
      end

      unique case (state_ff)
         ST_FIT:  limit_ff  <= prod[LIMIT_W-1:0];
         ST_WSUM: weight_ff <= (WGT_W'(wt_ff) << 8) + WGT_W'(prod);
         ST_BHI:  lo_ff     <= prod[RAND_W+31:0];
         ST_BCMP: begin
            wb_ff <= wb_in;
            mb_ff <= mb_in;
         end
         ST_DET2: rhs_ff <= prod[RHS_W-1:0];
         ST_DET3: begin
            rsp_wild_ff   <= OUT_CNT_W'(wt_ff);
            rsp_mutant_ff <= OUT_CNT_W'(mt_ff);
            rsp_det_ff    <= det_hit;
            rsp_total_ff  <= (det_hit && (det_total_ff != DET_MAX))
                             ? det_total_ff + DET_W'(1) : det_total_ff;
            rsp_fin_ff    <= steps_in >= STEPS_W'(limit_ff);
         end
         default: ;
      endcase
   end

   assign rsp_wild_count      = rsp_wild_ff;
   assign rsp_mutant_count    = rsp_mutant_ff;
   assign rsp_detected_now    = rsp_det_ff;
   assign rsp_detection_total = rsp_total_ff;
   assign rsp_finished        = rsp_fin_ff;

endmodule

`default_nettype wire
